/* rtl/bsa_pkg.sv */
// bsa_pkg: shared types and constants of the bitmap slot allocator
// used by bsa_byte_unit and bitmap_slot_allocator_core; no dependencies
package bsa_pkg;

    localparam int MAP_DEPTH = 32;
    localparam int IDX_W     = 5;
    localparam int BYTE_W    = 8;
    localparam int BIT_W     = 3;
    localparam int SIZE_W    = 6;

    localparam logic [BYTE_W-1:0] BYTE_FULL = 8'hff;
    localparam logic [BYTE_W-1:0] GROW_SEED = 8'h01;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef struct packed {
        logic              full;
        logic [BIT_W-1:0]  bit_idx;
        logic [BYTE_W-1:0] new_byte;
    } byte_res_t;

endpackage

/* rtl/bsa_byte_unit.sv */
// bsa_byte_unit: shared byte unit, finds the lowest clear bit and builds the updated byte
// depends on bsa_pkg
module bsa_byte_unit (
    input  logic                       func,
    input  logic [bsa_pkg::BYTE_W-1:0] byte_in,
    input  logic [bsa_pkg::BIT_W-1:0]  bit_sel,
    output bsa_pkg::byte_res_t         res
);

    logic [bsa_pkg::BIT_W-1:0] low_zero;

    always_comb
    begin
        low_zero = '0;
        for (int i = bsa_pkg::BYTE_W - 1; i >= 0; i--)
        begin
            if (!byte_in[i])
            begin
                low_zero = bsa_pkg::BIT_W'(i);
            end
        end
    end

    always_comb
    begin
        res.full    = (byte_in == bsa_pkg::BYTE_FULL);
        res.bit_idx = low_zero;
        unique case (func)
            bsa_pkg::FUNC_ALLOC: res.new_byte = byte_in | (bsa_pkg::BYTE_W'(1) << low_zero);
            bsa_pkg::FUNC_FREE:  res.new_byte = byte_in & ~(bsa_pkg::BYTE_W'(1) << bit_sel);
            default:             res.new_byte = byte_in;
        endcase
    end

endmodule

/* rtl/bitmap_slot_allocator_core.sv */
// bitmap_slot_allocator_core: top level of the first-free bitmap slot allocator
// depends on bsa_pkg and bsa_byte_unit
//
// usage:
//   input channel (in_valid/in_ready) carries one request: func 0 allocates the
//   lowest free slot, func 1 frees slot_to_free (negative or outside the active
//   region is ignored). output channel (out_valid/out_ready) returns one result
//   per request: slot and granted.
// timing:
//   one request at a time; in_ready is high only while the sequencer is idle.
//   the bitmap sits in a 32-byte memory with registered read, and the shared
//   byte unit looks at one byte at a time, first reading it and then evaluating it.
//   an allocate scans the active bytes from byte 0 up and, if all of them are full,
//   grows the active region or fails; a free updates one byte; an ignored free
//   goes straight to the result. in_ready returns in the same cycle as out_valid.
// reset:
//   rst_n clears every slot at once through per-byte valid bits, sets the
//   active size to INIT_BYTES and empties the output register.
// stall:
//   a result waits in the output register while out_ready is low; the block still
//   takes one new request, holds its result internally and then takes no more.
module bitmap_slot_allocator_core #(
    parameter int MAX_BYTES  = 32,
    parameter int GROW_BYTES = 4,
    parameter int INIT_BYTES = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       func,
    input  logic [8:0] slot_to_free,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] slot,
    output logic       granted
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_EVAL = 3'd2;
    localparam logic [2:0] S_GROW = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    localparam int SUM_W = bsa_pkg::SIZE_W + 1;

    logic [2:0]                     state_reg, state_next;
    logic [bsa_pkg::IDX_W-1:0]      idx_reg, idx_next;
    logic [bsa_pkg::BIT_W-1:0]      bit_reg, bit_next;
    logic                           func_reg, func_next;
    logic [bsa_pkg::SIZE_W-1:0]     active_reg, active_next;
    logic [bsa_pkg::MAP_DEPTH-1:0]  valid_reg, valid_next;
    logic [7:0]                     res_slot_reg, res_slot_next;
    logic                           res_granted_reg, res_granted_next;
    logic                           out_valid_reg, out_valid_next;
    logic [7:0]                     slot_reg, slot_next;
    logic                           granted_reg, granted_next;

    logic [bsa_pkg::BYTE_W-1:0]     map_mem [bsa_pkg::MAP_DEPTH];
    logic [bsa_pkg::BYTE_W-1:0]     map_q;
    logic                           mem_we;
    logic [bsa_pkg::IDX_W-1:0]      mem_wa;
    logic [bsa_pkg::BYTE_W-1:0]     mem_wd;

    logic [bsa_pkg::SIZE_W-1:0]     lim;
    logic [bsa_pkg::BYTE_W-1:0]     byte_val;
    bsa_pkg::byte_res_t             unit_res;
    logic [SUM_W-1:0]               grown;
    logic [bsa_pkg::SIZE_W-1:0]     idx_plus;
    logic                           accept;

    bsa_byte_unit u_unit (
        .func    (func_reg),
        .byte_in (byte_val),
        .bit_sel (bit_reg),
        .res     (unit_res)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[mem_wa] <= mem_wd;
        end
        map_q <= map_mem[idx_reg];
    end

    assign lim      = (active_reg < bsa_pkg::SIZE_W'(bsa_pkg::MAP_DEPTH))
                      ? active_reg : bsa_pkg::SIZE_W'(bsa_pkg::MAP_DEPTH);
    assign byte_val = valid_reg[idx_reg] ? map_q : '0;
    assign grown    = SUM_W'(active_reg) + SUM_W'(GROW_BYTES);
    assign idx_plus = bsa_pkg::SIZE_W'(idx_reg) + bsa_pkg::SIZE_W'(1);
    assign accept   = in_valid && in_ready;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign slot      = slot_reg;
    assign granted   = granted_reg;

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        bit_next         = bit_reg;
        func_next        = func_reg;
        active_next      = active_reg;
        valid_next       = valid_reg;
        res_slot_next    = res_slot_reg;
        res_granted_next = res_granted_reg;
        out_valid_next   = out_valid_reg;
        slot_next        = slot_reg;
        granted_next     = granted_reg;
        mem_we           = 1'b0;
        mem_wa           = idx_reg;
        mem_wd           = unit_res.new_byte;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    func_next        = func;
                    bit_next         = slot_to_free[2:0];
                    res_slot_next    = '0;
                    res_granted_next = 1'b0;
                    if (func == bsa_pkg::FUNC_ALLOC)
                    begin
                        idx_next   = '0;
                        state_next = (lim == '0) ? S_GROW : S_RD;
                    end
                    else if (slot_to_free[8]
                             || (bsa_pkg::SIZE_W'(slot_to_free[7:3]) >= lim))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next   = slot_to_free[7:3];
                        state_next = S_RD;
                    end
                end
            end
            S_RD:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (func_reg == bsa_pkg::FUNC_FREE)
                begin
                    mem_we             = 1'b1;
                    valid_next[idx_reg] = 1'b1;
                    res_granted_next   = 1'b1;
                    state_next         = S_DONE;
                end
                else if (!unit_res.full)
                begin
                    mem_we             = 1'b1;
                    valid_next[idx_reg] = 1'b1;
                    res_slot_next      = {idx_reg, unit_res.bit_idx};
                    res_granted_next   = 1'b1;
                    state_next         = S_DONE;
                end
                else if (idx_plus >= lim)
                begin
                    state_next = S_GROW;
                end
                else
                begin
                    idx_next   = idx_plus[bsa_pkg::IDX_W-1:0];
                    state_next = S_RD;
                end
            end
            S_GROW:
            begin
                if ((grown <= SUM_W'(MAX_BYTES))
                    && (active_reg < bsa_pkg::SIZE_W'(bsa_pkg::MAP_DEPTH)))
                begin
                    mem_we           = 1'b1;
                    mem_wa           = active_reg[bsa_pkg::IDX_W-1:0];
                    mem_wd           = bsa_pkg::GROW_SEED;
                    valid_next[active_reg[bsa_pkg::IDX_W-1:0]] = 1'b1;
                    res_slot_next    = {active_reg[bsa_pkg::IDX_W-1:0],
                                        bsa_pkg::BIT_W'(0)};
                    res_granted_next = 1'b1;
                    active_next      = grown[bsa_pkg::SIZE_W-1:0];
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    slot_next      = res_slot_reg;
                    granted_next   = res_granted_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            active_reg    <= bsa_pkg::SIZE_W'(INIT_BYTES);
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        bit_reg         <= bit_next;
        func_reg        <= func_next;
        res_slot_reg    <= res_slot_next;
        res_granted_reg <= res_granted_next;
        slot_reg        <= slot_next;
        granted_reg     <= granted_next;
    end

endmodule

/* rtl/bsa_checker.sv */
// bsa_checker: port-level assertions for bitmap_slot_allocator_core
// bound to the top level at the end of this file; no package dependency
module bsa_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] slot,
    input logic       granted
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(slot) && $stable(granted))
        else $error("result changed while stalled");

    // ungranted results (refused allocate or ignored free) carry slot zero
    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !granted |-> slot == 8'd0)
        else $error("nonzero slot without grant");

    // one request in flight
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while busy");

    // reset empties the output
    a_reset: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("output valid during reset");

endmodule

bind bitmap_slot_allocator_core bsa_checker u_bsa_checker (.*);
